// File: hw/rtl/knn_sorted_neighbor_list_defines.svh
// ----------------------------------------------------------------------------
// knn sorted neighbour list assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KNN_SORTED_NEIGHBOR_LIST_DEFINES_SVH
`define KNN_SORTED_NEIGHBOR_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define KNN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("knn list check failed");
`define KNN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knn list check failed");
`else
`define KNN_ASSERT_SAME(label, ante, cons)
`define KNN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// shared widths, action and status codes, cell control bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package knn_pkg;

  localparam int ACT_W  = 2;
  localparam int DIST_W = 32;
  localparam int NB_W   = 32;
  localparam int SLOT_W = 5;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_SAFE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BLIND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BADSLOT = 3'd4;

  // per-cell control from the list controller
  typedef struct packed {
    logic capture;  // beat accepted: take compare flags
    logic update;   // apply the insert/shift
    logic valid;    // cell holds a list entry
    logic lt_last;  // cell index below the last slot of this step
    logic le_last;  // cell index at or below the last slot of this step
  } knn_cell_ctl_t;

endpackage

// File: hw/rtl/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell
// one list slot: holds a pair, flags compare results, shifts from the left
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_cell (
  input  logic                        clk,
  input  knn_pkg::knn_cell_ctl_t      ctl,
  input  logic [knn_pkg::DIST_W-1:0]  in_dist,
  input  logic [knn_pkg::NB_W-1:0]    in_nb,
  input  logic [knn_pkg::DIST_W-1:0]  item_dist,
  input  logic [knn_pkg::NB_W-1:0]    item_nb,
  input  logic [knn_pkg::DIST_W-1:0]  left_dist,
  input  logic [knn_pkg::NB_W-1:0]    left_nb,
  input  logic                        left_gt,
  output logic [knn_pkg::DIST_W-1:0]  pair_dist,
  output logic [knn_pkg::NB_W-1:0]    nb,
  output logic                        gt,
  output logic                        dup,
  output logic                        lands
);
  import knn_pkg::*;

  logic [DIST_W-1:0] dist_r;
  logic [NB_W-1:0]   nb_r;
  logic              gt_r;
  logic              dup_r;
  logic              lt_r;
  logic              le_r;
  logic              shift;

  // new pair lands where the shifted run ends
  assign lands = le_r & (gt_r | ~lt_r) & ~left_gt;
  assign shift = le_r & left_gt;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      gt_r  <= ctl.lt_last & (in_dist < dist_r);
      dup_r <= ctl.valid & (nb_r == in_nb);
      lt_r  <= ctl.lt_last;
      le_r  <= ctl.le_last;
    end
    if (ctl.update) begin
      if (lands) begin
        dist_r <= item_dist;
        nb_r   <= item_nb;
      end else if (shift) begin
        dist_r <= left_dist;
        nb_r   <= left_nb;
      end
    end
  end

  assign pair_dist = dist_r;
  assign nb        = nb_r;
  assign gt        = gt_r;
  assign dup       = dup_r;

endmodule

// File: hw/rtl/knn_sorted_neighbor_list.sv
// ----------------------------------------------------------------------------
// knn_sorted_neighbor_list
// accepted beat is held and compare flags captured; the apply step then shifts the cells
// and loads the result register; no new item is taken until that step fires
// a stalled result holds the apply step until the output register drains
// reset: synchronous rst_n clears count and handshake state; pairs undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "knn_sorted_neighbor_list_defines.svh"

module knn_sorted_neighbor_list #(
  parameter int MAX_NEIGHBORS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [knn_pkg::ACT_W-1:0]     in_action,
  input  logic [knn_pkg::DIST_W-1:0]    in_distance,
  input  logic [knn_pkg::NB_W-1:0]      in_neighbor,
  input  logic [knn_pkg::SLOT_W-1:0]    in_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [knn_pkg::POS_W-1:0]     out_position,
  output logic [knn_pkg::STAT_W-1:0]    out_status,
  output logic [knn_pkg::DIST_W-1:0]    out_read_distance,
  output logic [knn_pkg::NB_W-1:0]      out_read_neighbor,
  output logic [knn_pkg::POS_W-1:0]     out_length
);
  import knn_pkg::*;

  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  // only the first slots are reachable through the read port
  localparam int RD_N  = (MAX_NEIGHBORS < (1 << SLOT_W)) ? MAX_NEIGHBORS : (1 << SLOT_W);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  // controller state
  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // held beat
  logic [ACT_W-1:0]  act_r;
  logic [DIST_W-1:0] item_dist_r;
  logic [NB_W-1:0]   item_nb_r;
  logic [SLOT_W-1:0] slot_r;
  logic              rd_ok_r;
  logic [DIST_W-1:0] rd_dist_r;
  logic [NB_W-1:0]   rd_nb_r;

  // result register
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [DIST_W-1:0] odist_r;
  logic [NB_W-1:0]   onb_r;
  logic [POS_W-1:0]  len_r;

  // cell row
  logic [DIST_W-1:0] cell_dist [MAX_NEIGHBORS];
  logic [NB_W-1:0]   cell_nb   [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] cell_gt;
  logic [MAX_NEIGHBORS-1:0] cell_dup;
  logic [MAX_NEIGHBORS-1:0] lands;

  logic              accept;
  logic              fire;
  logic              is_append;
  logic              cnt_zero;
  logic              cnt_full;
  logic              dup_any;
  logic              do_write;
  logic              rd_ok;
  logic [DIST_W-1:0] rd_dist;
  logic [NB_W-1:0]   rd_nb;
  logic [IDX_W-1:0]  land_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  // apply step waits for a free result register
  assign fire      = (state_r == ST_APPLY) & (~out_valid_r | out_ready);
  assign is_append = (act_r == ACT_APPEND);
  assign cnt_zero  = (count_r == '0);
  assign cnt_full  = (count_r >= CNT_W'(MAX_NEIGHBORS));
  assign dup_any   = |cell_dup;

  // writes moving pairs: append with room, insert into non-empty list (safe: no dup)
  always_comb begin
    case (act_r)
      ACT_APPEND: do_write = ~cnt_full;
      ACT_BLIND:  do_write = ~cnt_zero;
      ACT_SAFE:   do_write = ~cnt_zero & ~dup_any;
      default:    do_write = 1'b0;
    endcase
  end

  // read port: and-or select over the addressable slots
  assign rd_ok = (32'(in_slot) < 32'(count_r));
  always_comb begin
    rd_dist = '0;
    rd_nb   = '0;
    for (int j = 0; j < RD_N; j++) begin
      if (in_slot == SLOT_W'(j)) begin
        rd_dist = rd_dist | cell_dist[j];
        rd_nb   = rd_nb | cell_nb[j];
      end
    end
  end

  // one-hot landing flag to slot number
  always_comb begin
    land_idx = '0;
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      if (lands[j]) begin
        land_idx = land_idx | IDX_W'(j);
      end
    end
  end

  // chain of cells; last slot is the old count for append, count - 1 otherwise
  for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_cell
    knn_cell_ctl_t     ctl;
    logic [DIST_W-1:0] left_dist;
    logic [NB_W-1:0]   left_nb;
    logic              left_gt;

    assign ctl.capture = accept;
    assign ctl.update  = fire & do_write;
    assign ctl.valid   = (32'(count_r) > j);
    assign ctl.lt_last = (in_action == ACT_APPEND) ? (32'(count_r) > j)
                                                   : (32'(count_r) > j + 1);
    assign ctl.le_last = (in_action == ACT_APPEND) ? (32'(count_r) >= j)
                                                   : (32'(count_r) > j);

    if (j == 0) begin : g_head
      assign left_dist = item_dist_r;
      assign left_nb   = item_nb_r;
      assign left_gt   = 1'b0;
    end else begin : g_body
      assign left_dist = cell_dist[j-1];
      assign left_nb   = cell_nb[j-1];
      assign left_gt   = cell_gt[j-1];
    end

    knn_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_dist   (in_distance),
      .in_nb     (in_neighbor),
      .item_dist (item_dist_r),
      .item_nb   (item_nb_r),
      .left_dist (left_dist),
      .left_nb   (left_nb),
      .left_gt   (left_gt),
      .pair_dist (cell_dist[j]),
      .nb        (cell_nb[j]),
      .gt        (cell_gt[j]),
      .dup       (cell_dup[j]),
      .lands     (lands[j])
    );
  end

  // result fields and next count
  always_comb begin
    pos_nxt   = POS_W'(land_idx);
    stat_nxt  = STAT_OK;
    count_nxt = count_r;
    case (act_r)
      ACT_READ: begin
        pos_nxt  = POS_W'(slot_r);
        stat_nxt = rd_ok_r ? STAT_OK : STAT_BADSLOT;
      end
      ACT_APPEND: begin
        if (cnt_full) begin
          pos_nxt  = POS_W'(count_r);
          stat_nxt = STAT_FULL;
        end else begin
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      default: begin
        if (cnt_zero) begin
          pos_nxt  = '0;
          stat_nxt = STAT_EMPTY;
        end else if ((act_r == ACT_SAFE) && dup_any) begin
          pos_nxt  = POS_W'(count_r);
          stat_nxt = STAT_DUP;
        end
      end
    endcase
    if (!fire) begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_APPLY: if (fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // held beat and read data captured in the accept cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r       <= in_action;
      item_dist_r <= in_distance;
      item_nb_r   <= in_neighbor;
      slot_r      <= in_slot;
      rd_ok_r     <= rd_ok;
      rd_dist_r   <= rd_ok ? rd_dist : '0;
      rd_nb_r     <= rd_ok ? rd_nb : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_r   <= pos_nxt;
      stat_r  <= stat_nxt;
      odist_r <= (act_r == ACT_READ) ? rd_dist_r : '0;
      onb_r   <= (act_r == ACT_READ) ? rd_nb_r : '0;
      len_r   <= POS_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = pos_r;
  assign out_status        = stat_r;
  assign out_read_distance = odist_r;
  assign out_read_neighbor = onb_r;
  assign out_length        = len_r;

  // checks
  `KNN_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_NEIGHBORS))
  `KNN_ASSERT_SAME(a_lands_onehot, fire && do_write, $onehot(lands))
  `KNN_ASSERT_NEXT(a_accept_apply, accept, state_r == ST_APPLY)
  `KNN_ASSERT_NEXT(a_count_hold, !(fire && is_append && !cnt_full), $stable(count_r))

endmodule
